// ----- hw/rtl/bitmap_font_text_blitter_defines.svh -----
// Assertion macros shared by the blitter RTL.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef BITMAP_FONT_TEXT_BLITTER_DEFINES_SVH
`define BITMAP_FONT_TEXT_BLITTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFTB_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bftb: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BFTB_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bftb: next-cycle check failed");

`endif

// ----- hw/rtl/bftb_pkg.sv -----
`default_nettype none

package bftb_pkg;

  // Screen and font limits.
  localparam int SCREEN_WIDTH     = 240;
  localparam int SCREEN_HEIGHT    = 240;
  localparam int MAX_GLYPH_WIDTH  = 32;
  localparam int MAX_GLYPH_HEIGHT = 48;
  localparam int GLYPH_COUNT      = 95;

  // The bitmap store is a power of two deep, so address wrap is a plain overflow.
  localparam int BM_AW        = 13;
  localparam int BITMAP_BYTES = 2 ** BM_AW;
  localparam int BANKS        = 4;
  localparam int BANK_AW      = BM_AW - 2;
  localparam int BANK_DEPTH   = BITMAP_BYTES / BANKS;

  // Drawn columns and rows per glyph.
  localparam int SPAN_W  = 32;
  localparam int COL_CAP = (MAX_GLYPH_WIDTH < SPAN_W) ? MAX_GLYPH_WIDTH : SPAN_W;
  localparam int ROW_CAP = (MAX_GLYPH_HEIGHT < 48) ? MAX_GLYPH_HEIGHT : 48;

  // Character codes.
  localparam logic [7:0] FIRST_CODE   = 8'h20;
  localparam logic [7:0] LAST_CODE    = 8'h7E;
  localparam logic [7:0] NEWLINE_CODE = 8'h0A;

  // Configuration registers and their reset values.
  localparam logic       CFG_IDX_LINE_SPACING = 1'b0;
  localparam logic       CFG_IDX_MISSING_ADV  = 1'b1;
  localparam logic [7:0] LINE_SPACING_RST     = 8'd38;
  localparam logic [7:0] MISSING_ADV_RST      = 8'd6;

  typedef enum logic [1:0] {
    FUNC_LOAD_METRICS = 2'd0,
    FUNC_LOAD_BITMAP  = 2'd1,
    FUNC_START        = 2'd2,
    FUNC_CHAR         = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DRAW
  } state_t;

  // One glyph table entry.
  typedef struct packed {
    logic [5:0]  width;
    logic [5:0]  height;
    logic [12:0] offset;
  } glyph_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic latch;
    logic draw;
    logic finish;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_draw;
    logic draw_done;
    logic pend_valid;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bftb_if.sv -----
`default_nettype none

// Input channel: one transaction per load, start or character item.
interface bftb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [15:0] pen_in;
  logic [7:0]  char_code;
  logic [6:0]  glyph_slot;
  logic [5:0]  glyph_width;
  logic [5:0]  glyph_height;
  logic [12:0] glyph_offset;
  logic [12:0] bitmap_addr;
  logic [7:0]  bitmap_byte;

  modport source (
    output valid, func, pos_x, pos_y, pen_in, char_code, glyph_slot,
           glyph_width, glyph_height, glyph_offset, bitmap_addr, bitmap_byte,
    input  ready
  );
  modport sink (
    input  valid, func, pos_x, pos_y, pen_in, char_code, glyph_slot,
           glyph_width, glyph_height, glyph_offset, bitmap_addr, bitmap_byte,
    output ready
  );
endinterface

// Result channel: one transaction per painted span.
interface bftb_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  row_y;
  logic [15:0] span_x;
  logic [31:0] pixel_mask;
  logic [15:0] pen_out;
  logic        last;

  modport source (
    output valid, row_y, span_x, pixel_mask, pen_out, last,
    input  ready
  );
  modport sink (
    input  valid, row_y, span_x, pixel_mask, pen_out, last,
    output ready
  );
endinterface

`default_nettype wire

// ----- hw/rtl/bitmap_font_text_blitter.sv -----
// Bitmap font text blitter.
// The input channel in_ch carries one transaction per item: a glyph metrics
// load, a bitmap byte load, a start-text item, or a character. Loads, start
// items, newlines and codes outside the font are accepted while the block
// stays idle and yield no result. A printable character reads its metrics,
// then streams its glyph rows through the four-bank bitmap store at one row
// per cycle while the result channel does not stall, and frees the input once
// every row is read and no span is left pending. Each painted row leaves on
// out_ch as one span transaction, and the final span of a character carries
// last. A span leaves only once the next painted row or the end of the glyph
// shows whether it is the last, so the first span of a character waits in the
// pending register until its second painted row is read, or until the end of
// the glyph when only one row paints. One result waits in the output register, so
// when out_ch stalls the row pipeline freezes in place and resumes without loss.
// line_spacing and missing_advance are written over the APB port.
// Synchronous reset clears the cursor, origin and pen to zero and the
// registers to 38 and 6; glyph metrics and bitmap bytes must be loaded before
// they are drawn.
`default_nettype none

`include "bitmap_font_text_blitter_defines.svh"

module bitmap_font_text_blitter import bftb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  bftb_in_if.sink          in_ch,
  bftb_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [7:0] line_spacing_r, line_spacing_nxt;
  logic [7:0] missing_adv_r, missing_adv_nxt;
  logic       cfg_write;
  dp_cmd_t    dp_cmd;
  dp_sts_t    dp_sts;

  // Configuration registers; the word index is paddr[2].
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    line_spacing_nxt = line_spacing_r;
    missing_adv_nxt  = missing_adv_r;
    if (cfg_write) begin
      case (paddr[2])
        CFG_IDX_LINE_SPACING: line_spacing_nxt = pwdata[7:0];
        CFG_IDX_MISSING_ADV:  missing_adv_nxt  = pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_spacing_r <= LINE_SPACING_RST;
      missing_adv_r  <= MISSING_ADV_RST;
    end else begin
      line_spacing_r <= line_spacing_nxt;
      missing_adv_r  <= missing_adv_nxt;
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[2])
      CFG_IDX_LINE_SPACING: prdata = {24'b0, line_spacing_r};
      CFG_IDX_MISSING_ADV:  prdata = {24'b0, missing_adv_r};
      default:              prdata = '0;
    endcase
  end

  // Sequencer.
  bftb_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .sts     (dp_sts),
    .cmd     (dp_cmd)
  );

  // Tables, cursor and span pipeline.
  bftb_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (dp_cmd),
    .sts            (dp_sts),
    .func           (in_ch.func),
    .pos_x          (in_ch.pos_x),
    .pos_y          (in_ch.pos_y),
    .pen_in         (in_ch.pen_in),
    .char_code      (in_ch.char_code),
    .glyph_slot     (in_ch.glyph_slot),
    .glyph_width    (in_ch.glyph_width),
    .glyph_height   (in_ch.glyph_height),
    .glyph_offset   (in_ch.glyph_offset),
    .bitmap_addr    (in_ch.bitmap_addr),
    .bitmap_byte    (in_ch.bitmap_byte),
    .line_spacing   (line_spacing_r),
    .missing_advance(missing_adv_r),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .row_y          (out_ch.row_y),
    .span_x         (out_ch.span_x),
    .pixel_mask     (out_ch.pixel_mask),
    .pen_out        (out_ch.pen_out),
    .last           (out_ch.last)
  );

  // A drawn character holds off the next input transaction in the cycle after it is taken.
  `BFTB_ASSERT_NEXT(a_draw_blocks_input, in_ch.valid && in_ch.ready && dp_sts.is_draw, !in_ch.ready)

  // An item that draws nothing never creates a span.
  `BFTB_ASSERT_NEXT(a_no_spurious_span, in_ch.valid && in_ch.ready && !dp_sts.is_draw && !out_ch.valid, !out_ch.valid)

  // No span of a finished character is left pending when a new item arrives.
  `BFTB_ASSERT_IMPL(a_pending_flushed, in_ch.valid && in_ch.ready, !dp_sts.pend_valid)

endmodule

`default_nettype wire

// ----- hw/rtl/bftb_ram.sv -----
`default_nettype none

// Single-port-write, single-port-read RAM with a registered read.
module bftb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bftb_datapath.sv -----
`default_nettype none

module bftb_datapath import bftb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire dp_cmd_t     cmd,
  output dp_sts_t          sts,
  // Input payload.
  input  wire logic [1:0]  func,
  input  wire logic [15:0] pos_x,
  input  wire logic [15:0] pos_y,
  input  wire logic [15:0] pen_in,
  input  wire logic [7:0]  char_code,
  input  wire logic [6:0]  glyph_slot,
  input  wire logic [5:0]  glyph_width,
  input  wire logic [5:0]  glyph_height,
  input  wire logic [12:0] glyph_offset,
  input  wire logic [12:0] bitmap_addr,
  input  wire logic [7:0]  bitmap_byte,
  // Configuration.
  input  wire logic [7:0]  line_spacing,
  input  wire logic [7:0]  missing_advance,
  // Result channel.
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       row_y,
  output logic [15:0]      span_x,
  output logic [31:0]      pixel_mask,
  output logic [15:0]      pen_out,
  output logic             last
);

  // Text state.
  logic [15:0] cursor_x_r, cursor_x_nxt;
  logic [15:0] cursor_y_r, cursor_y_nxt;
  logic [15:0] origin_x_r, origin_x_nxt;
  logic [15:0] pen_r, pen_nxt;

  // Current glyph.
  logic [5:0]        width_r, width_nxt;
  logic [5:0]        rows_r, rows_nxt;
  logic [3:0]        bpr_r, bpr_nxt;
  logic [5:0]        row_cnt_r, row_cnt_nxt;
  logic [BM_AW-1:0]  row_addr_r, row_addr_nxt;
  logic [SPAN_W-1:0] colmask_r, colmask_nxt;

  // Read stage: row whose bytes are coming out of the banks.
  logic        b_valid_r, b_valid_nxt;
  logic [16:0] b_py_r, b_py_nxt;
  logic [1:0]  b_lane_r, b_lane_nxt;

  // Pending span, held until it is known whether it is the last one.
  logic              pend_valid_r, pend_valid_nxt;
  logic [7:0]        pend_y_r, pend_y_nxt;
  logic [SPAN_W-1:0] pend_mask_r, pend_mask_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_y_r, out_y_nxt;
  logic [15:0]       out_x_r, out_x_nxt;
  logic [SPAN_W-1:0] out_mask_r, out_mask_nxt;
  logic [15:0]       out_pen_r, out_pen_nxt;
  logic              out_last_r, out_last_nxt;

  // Memory ports.
  glyph_t             gt_wdata;
  glyph_t             gt_rdata;
  logic               gt_we;
  logic               gt_re;
  logic [6:0]         gt_raddr;
  logic [BANKS-1:0]   bank_we;
  logic [BANK_AW-1:0] bank_raddr [BANKS];
  logic [7:0]         bank_rdata [BANKS];
  logic               bank_re;

  // Helpers.
  logic              is_draw;
  logic [5:0]        cols;
  logic [7:0]        row_bytes [BANKS];
  logic [SPAN_W-1:0] row_mask;
  logic              b_hit;
  logic              adv;
  logic              issue;
  logic              rows_left;
  logic              flush;

  // Item decode.
  assign is_draw = (func == FUNC_CHAR) && (char_code >= FIRST_CODE) &&
                   (char_code <= LAST_CODE);

  // Glyph metrics table.
  assign gt_we    = cmd.accept && (func == FUNC_LOAD_METRICS) &&
                    (32'(glyph_slot) < GLYPH_COUNT);
  assign gt_wdata = '{width: glyph_width, height: glyph_height, offset: glyph_offset};
  assign gt_re    = cmd.accept && is_draw;
  assign gt_raddr = 7'(char_code - FIRST_CODE);

  bftb_ram #(
    .WIDTH($bits(glyph_t)),
    .DEPTH(GLYPH_COUNT)
  ) u_glyph_ram (
    .clk  (clk),
    .we   (gt_we),
    .waddr(glyph_slot),
    .wdata(gt_wdata),
    .re   (gt_re),
    .raddr(gt_raddr),
    .rdata(gt_rdata)
  );

  // Bitmap store in four byte banks, so any four consecutive bytes read in the same cycle.
  assign adv       = !out_valid_r || out_ready;
  assign rows_left = (row_cnt_r != rows_r);
  assign issue     = cmd.draw && adv && rows_left;
  assign bank_re   = issue;

  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    logic [1:0]       lane_ofs;
    logic [BM_AW-1:0] byte_addr;

    assign bank_we[b] = cmd.accept && (func == FUNC_LOAD_BITMAP) &&
                        (32'(bitmap_addr) < BITMAP_BYTES) &&
                        (bitmap_addr[1:0] == 2'(b));
    assign lane_ofs      = 2'(b) - row_addr_r[1:0];
    assign byte_addr     = row_addr_r + BM_AW'(lane_ofs);
    assign bank_raddr[b] = byte_addr[BM_AW-1:2];

    bftb_ram #(
      .WIDTH(8),
      .DEPTH(BANK_DEPTH)
    ) u_bank_ram (
      .clk  (clk),
      .we   (bank_we[b]),
      .waddr(bitmap_addr[BM_AW-1:2]),
      .wdata(bitmap_byte),
      .re   (bank_re),
      .raddr(bank_raddr[b]),
      .rdata(bank_rdata[b])
    );
  end

  // Reorder the bank outputs into row byte order and build the clipped mask.
  always_comb begin
    for (int k = 0; k < BANKS; k++) begin
      row_bytes[k] = bank_rdata[2'(b_lane_r + 2'(k))];
    end
    for (int c = 0; c < SPAN_W; c++) begin
      row_mask[c] = row_bytes[c >> 3][7 - (c & 7)] & colmask_r[c];
    end
  end

  assign b_hit = b_valid_r && (b_py_r < 17'(SCREEN_HEIGHT)) && (row_mask != '0);
  assign flush = cmd.draw && !rows_left && !b_valid_r && pend_valid_r;

  // Drawn column count of the glyph being fetched.
  assign cols = (gt_rdata.width > 6'(COL_CAP)) ? 6'(COL_CAP) : gt_rdata.width;

  // Next-state logic.
  always_comb begin
    cursor_x_nxt   = cursor_x_r;
    cursor_y_nxt   = cursor_y_r;
    origin_x_nxt   = origin_x_r;
    pen_nxt        = pen_r;
    width_nxt      = width_r;
    rows_nxt       = rows_r;
    bpr_nxt        = bpr_r;
    row_cnt_nxt    = row_cnt_r;
    row_addr_nxt   = row_addr_r;
    colmask_nxt    = colmask_r;
    b_valid_nxt    = b_valid_r;
    b_py_nxt       = b_py_r;
    b_lane_nxt     = b_lane_r;
    pend_valid_nxt = pend_valid_r;
    pend_y_nxt     = pend_y_r;
    pend_mask_nxt  = pend_mask_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_y_nxt      = out_y_r;
    out_x_nxt      = out_x_r;
    out_mask_nxt   = out_mask_r;
    out_pen_nxt    = out_pen_r;
    out_last_nxt   = out_last_r;

    // Start text and cursor moves take effect with the input transaction.
    if (cmd.accept) begin
      case (func)
        FUNC_START: begin
          origin_x_nxt = pos_x;
          cursor_x_nxt = pos_x;
          cursor_y_nxt = pos_y;
          pen_nxt      = pen_in;
        end
        FUNC_CHAR: begin
          if (char_code == NEWLINE_CODE) begin
            cursor_y_nxt = cursor_y_r + 16'(line_spacing);
            cursor_x_nxt = origin_x_r;
          end else if (!is_draw) begin
            cursor_x_nxt = cursor_x_r + 16'(missing_advance);
          end
        end
        default: begin
        end
      endcase
    end

    // Capture the glyph metrics and the column clip mask.
    if (cmd.latch) begin
      width_nxt    = gt_rdata.width;
      rows_nxt     = (gt_rdata.height > 6'(ROW_CAP)) ? 6'(ROW_CAP) : gt_rdata.height;
      bpr_nxt      = 4'((7'(gt_rdata.width) + 7'd7) >> 3);
      row_cnt_nxt  = '0;
      row_addr_nxt = gt_rdata.offset;
      for (int c = 0; c < SPAN_W; c++) begin
        colmask_nxt[c] = (6'(c) < cols) &&
                         ((17'(cursor_x_r) + 17'(c)) < 17'(SCREEN_WIDTH));
      end
    end

    // Row pipeline: issue a row read, then sort the span into pending or output.
    if (cmd.draw && adv) begin
      if (issue) begin
        row_cnt_nxt  = row_cnt_r + 6'd1;
        row_addr_nxt = row_addr_r + BM_AW'(bpr_r);
        b_valid_nxt  = 1'b1;
        b_py_nxt     = 17'(cursor_y_r) + 17'(row_cnt_r);
        b_lane_nxt   = row_addr_r[1:0];
      end else begin
        b_valid_nxt = 1'b0;
      end

      if (b_hit) begin
        if (pend_valid_r) begin
          out_valid_nxt = 1'b1;
          out_y_nxt     = pend_y_r;
          out_x_nxt     = cursor_x_r;
          out_mask_nxt  = pend_mask_r;
          out_pen_nxt   = pen_r;
          out_last_nxt  = 1'b0;
        end
        pend_valid_nxt = 1'b1;
        pend_y_nxt     = b_py_r[7:0];
        pend_mask_nxt  = row_mask;
      end else if (flush) begin
        out_valid_nxt  = 1'b1;
        out_y_nxt      = pend_y_r;
        out_x_nxt      = cursor_x_r;
        out_mask_nxt   = pend_mask_r;
        out_pen_nxt    = pen_r;
        out_last_nxt   = 1'b1;
        pend_valid_nxt = 1'b0;
      end
    end

    // Advance past the drawn glyph.
    if (cmd.finish) begin
      cursor_x_nxt = cursor_x_r + 16'(width_r);
    end
  end

  // Control and text state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r   <= '0;
      cursor_y_r   <= '0;
      origin_x_r   <= '0;
      pen_r        <= '0;
      rows_r       <= '0;
      row_cnt_r    <= '0;
      b_valid_r    <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      cursor_x_r   <= cursor_x_nxt;
      cursor_y_r   <= cursor_y_nxt;
      origin_x_r   <= origin_x_nxt;
      pen_r        <= pen_nxt;
      rows_r       <= rows_nxt;
      row_cnt_r    <= row_cnt_nxt;
      b_valid_r    <= b_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    width_r     <= width_nxt;
    bpr_r       <= bpr_nxt;
    row_addr_r  <= row_addr_nxt;
    colmask_r   <= colmask_nxt;
    b_py_r      <= b_py_nxt;
    b_lane_r    <= b_lane_nxt;
    pend_y_r    <= pend_y_nxt;
    pend_mask_r <= pend_mask_nxt;
    out_y_r     <= out_y_nxt;
    out_x_r     <= out_x_nxt;
    out_mask_r  <= out_mask_nxt;
    out_pen_r   <= out_pen_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Status to the controller.
  assign sts.is_draw    = is_draw;
  assign sts.draw_done  = !rows_left && !b_valid_r && !pend_valid_r;
  assign sts.pend_valid = pend_valid_r;

  // Result channel.
  assign out_valid  = out_valid_r;
  assign row_y      = out_y_r;
  assign span_x     = out_x_r;
  assign pixel_mask = out_mask_r;
  assign pen_out    = out_pen_r;
  assign last       = out_last_r;

endmodule

`default_nettype wire

// ----- hw/rtl/bftb_ctrl.sv -----
`default_nettype none

module bftb_ctrl import bftb_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && sts.is_draw) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd.latch = 1'b1;
        state_nxt = ST_DRAW;
      end
      ST_DRAW: begin
        cmd.draw = 1'b1;
        if (sts.draw_done) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- verif/bitmap_font_text_blitter_test.sv -----
import bftb_pkg::*;

// One input transaction, with every field of the channel.
typedef struct {
  func_t       func;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [15:0] pen_in;
  logic [7:0]  char_code;
  logic [6:0]  glyph_slot;
  logic [5:0]  glyph_width;
  logic [5:0]  glyph_height;
  logic [12:0] glyph_offset;
  logic [12:0] bitmap_addr;
  logic [7:0]  bitmap_byte;
} text_item_t;

// One painted span as it leaves the result channel.
typedef struct {
  logic [7:0]  row_y;
  logic [15:0] span_x;
  logic [31:0] pixel_mask;
  logic [15:0] pen_out;
  logic        last;
} span_t;

// Tracks the font, cursor and pen, and holds the spans still owed by the block.
class span_ledger;
  logic [7:0]  line_gap;
  logic [7:0]  miss_adv;
  logic [15:0] cur_x;
  logic [15:0] cur_y;
  logic [15:0] org_x;
  logic [15:0] pen;
  glyph_t      glyphs [GLYPH_COUNT];
  bit          glyph_set [GLYPH_COUNT];
  logic [7:0]  bitmap [BITMAP_BYTES];
  bit          byte_set [BITMAP_BYTES];
  span_t       pending [$];
  int          spans_made;
  int          errors;

  function new();
    line_gap   = LINE_SPACING_RST;
    miss_adv   = MISSING_ADV_RST;
    cur_x      = '0;
    cur_y      = '0;
    org_x      = '0;
    pen        = '0;
    spans_made = 0;
    errors     = 0;
  endfunction

  function void set_reg(input logic idx, input logic [7:0] value);
    if (idx == CFG_IDX_LINE_SPACING) begin
      line_gap = value;
    end else begin
      miss_adv = value;
    end
  endfunction

  // Apply one accepted transaction and queue the spans it paints.
  function void take_item(input text_item_t it);
    glyph_t      g;
    int          s;
    int          bpr;
    int          cols;
    int          rows;
    int unsigned py;
    logic [31:0] mask;
    logic [7:0]  b;
    span_t       sp;
    span_t       drawn [$];
    case (it.func)
      FUNC_LOAD_METRICS: begin
        if (it.glyph_slot < GLYPH_COUNT) begin
          glyphs[it.glyph_slot]    = {it.glyph_width, it.glyph_height, it.glyph_offset};
          glyph_set[it.glyph_slot] = 1'b1;
        end
      end
      FUNC_LOAD_BITMAP: begin
        bitmap[it.bitmap_addr]   = it.bitmap_byte;
        byte_set[it.bitmap_addr] = 1'b1;
      end
      FUNC_START: begin
        org_x = it.pos_x;
        cur_x = it.pos_x;
        cur_y = it.pos_y;
        pen   = it.pen_in;
      end
      default: begin
        if (it.char_code == NEWLINE_CODE) begin
          cur_y = cur_y + 16'(line_gap);
          cur_x = org_x;
        end else if (it.char_code >= FIRST_CODE && it.char_code <= LAST_CODE) begin
          s    = int'(it.char_code - FIRST_CODE);
          g    = glyphs[s];
          bpr  = (int'(g.width) + 7) / 8;
          cols = (g.width > COL_CAP) ? COL_CAP : int'(g.width);
          rows = (g.height > ROW_CAP) ? ROW_CAP : int'(g.height);
          // Rows and columns are placed without 16-bit wrap, then clipped.
          for (int r = 0; r < rows; r++) begin
            py = cur_y + r;
            if (py >= SCREEN_HEIGHT) continue;
            mask = '0;
            for (int c = 0; c < cols; c++) begin
              b = bitmap[(g.offset + r * bpr + c / 8) % BITMAP_BYTES];
              if (b[7 - c % 8] && (cur_x + c < SCREEN_WIDTH)) mask[c] = 1'b1;
            end
            if (mask != '0) begin
              sp.row_y      = py[7:0];
              sp.span_x     = cur_x;
              sp.pixel_mask = mask;
              sp.pen_out    = pen;
              sp.last       = 1'b0;
              drawn.push_back(sp);
            end
          end
          if (drawn.size() > 0) drawn[drawn.size() - 1].last = 1'b1;
          foreach (drawn[i]) pending.push_back(drawn[i]);
          spans_made += drawn.size();
          cur_x = cur_x + 16'(g.width);
        end else begin
          cur_x = cur_x + 16'(miss_adv);
        end
      end
    endcase
  endfunction

  // Compare one received span with the oldest one owed.
  function void match_span(input span_t got);
    span_t want;
    if (pending.size() == 0) begin
      errors++;
      $display("%0t: unexpected span, expected none, got row %0d x %0d mask %h pen %h last %0d",
               $time, got.row_y, got.span_x, got.pixel_mask, got.pen_out, got.last);
      return;
    end
    want = pending.pop_front();
    if (got.row_y !== want.row_y || got.span_x !== want.span_x ||
        got.pixel_mask !== want.pixel_mask || got.pen_out !== want.pen_out ||
        got.last !== want.last) begin
      errors++;
      $display("%0t: span mismatch, expected row %0d x %0d mask %h pen %h last %0d",
               $time, want.row_y, want.span_x, want.pixel_mask, want.pen_out, want.last);
      $display("%0t: span mismatch, actual   row %0d x %0d mask %h pen %h last %0d",
               $time, got.row_y, got.span_x, got.pixel_mask, got.pen_out, got.last);
    end
  endfunction
endclass

module bitmap_font_text_blitter_test;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_AFTER   = 40;
  localparam int HOLD_CYCLES  = 300;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  wire  [31:0] prdata;
  wire         pready;

  bit         calm = 1'b0;
  int         items_sent = 0;
  int         spans_accepted = 0;
  int         cycles = 0;
  span_ledger ledger;

  bftb_in_if  in_ch ();
  bftb_out_if out_ch ();

  bitmap_font_text_blitter u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Give up on a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Every span transaction goes to the ledger for checking.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      ledger.match_span(span_t'{out_ch.row_y, out_ch.span_x, out_ch.pixel_mask,
                                out_ch.pen_out, out_ch.last});
      spans_accepted++;
    end
  end

  // Result side: random stalls, plus one long hold-off while input keeps coming.
  initial begin : result_sink
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && spans_accepted >= HOLD_AFTER) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 23);
      end
    end
  end

  // Random filler for the fields that a transaction does not use.
  function automatic text_item_t noisy_item(input func_t f);
    text_item_t it;
    it.func         = f;
    it.pos_x        = 16'($urandom);
    it.pos_y        = 16'($urandom);
    it.pen_in       = 16'($urandom);
    it.char_code    = 8'($urandom);
    it.glyph_slot   = 7'($urandom);
    it.glyph_width  = 6'($urandom);
    it.glyph_height = 6'($urandom);
    it.glyph_offset = 13'($urandom);
    it.bitmap_addr  = 13'($urandom);
    it.bitmap_byte  = 8'($urandom);
    return it;
  endfunction

  // Offer one transaction, with random gaps, and wait until it is taken.
  task automatic send_item(input text_item_t it);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 23) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= it.func;
    in_ch.pos_x        <= it.pos_x;
    in_ch.pos_y        <= it.pos_y;
    in_ch.pen_in       <= it.pen_in;
    in_ch.char_code    <= it.char_code;
    in_ch.glyph_slot   <= it.glyph_slot;
    in_ch.glyph_width  <= it.glyph_width;
    in_ch.glyph_height <= it.glyph_height;
    in_ch.glyph_offset <= it.glyph_offset;
    in_ch.bitmap_addr  <= it.bitmap_addr;
    in_ch.bitmap_byte  <= it.bitmap_byte;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ledger.take_item(it);
    items_sent++;
  endtask

  task automatic load_glyph(input logic [6:0] slot, input logic [5:0] w,
                            input logic [5:0] h, input logic [12:0] off);
    text_item_t it;
    it = noisy_item(FUNC_LOAD_METRICS);
    it.glyph_slot   = slot;
    it.glyph_width  = w;
    it.glyph_height = h;
    it.glyph_offset = off;
    send_item(it);
  endtask

  task automatic load_byte(input logic [12:0] addr, input logic [7:0] data);
    text_item_t it;
    it = noisy_item(FUNC_LOAD_BITMAP);
    it.bitmap_addr = addr;
    it.bitmap_byte = data;
    send_item(it);
  endtask

  task automatic start_text(input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] color);
    text_item_t it;
    it = noisy_item(FUNC_START);
    it.pos_x  = x;
    it.pos_y  = y;
    it.pen_in = color;
    send_item(it);
  endtask

  task automatic put_char(input logic [7:0] code);
    text_item_t it;
    it = noisy_item(FUNC_CHAR);
    it.char_code = code;
    send_item(it);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic idx, input logic [7:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    ledger.set_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Stop offering, wait for every owed span, then let the glyph pipeline drain.
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (ledger.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random traffic: font loads, text starts, character strings and some noise.
  task automatic run_random(input int goal, input int min_spans);
    int         base;
    int         pick;
    int         slot;
    int         w;
    int         h;
    int         off;
    int         rows;
    int         n;
    bit         ok;
    logic [7:0] data;
    logic [7:0] code;
    int         ready_slots [$];
    base = ledger.spans_made;
    while (items_sent < goal || ledger.spans_made - base < min_spans) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        // Metrics for one glyph, then any bitmap bytes it still lacks.
        slot = $urandom_range(GLYPH_COUNT - 1);
        if ($urandom_range(9) == 0) begin
          h = MAX_GLYPH_HEIGHT;
          w = $urandom_range(8, 1);
        end else begin
          h = $urandom_range(12);
          w = $urandom_range(32);
        end
        off = ($urandom_range(7) == 0) ? $urandom_range(8191, 8150) : $urandom_range(63);
        load_glyph(7'(slot), 6'(w), 6'(h), 13'(off));
        n = h * ((w + 7) / 8);
        for (int i = 0; i < n; i++) begin
          if (!ledger.byte_set[(off + i) % BITMAP_BYTES]) begin
            case ($urandom_range(3))
              0: data = 8'hFF;
              1: data = 8'h00;
              default: data = 8'($urandom);
            endcase
            load_byte(13'((off + i) % BITMAP_BYTES), data);
          end
        end
      end else if (pick < 35) begin
        if ($urandom_range(4) == 0) begin
          start_text(16'($urandom), 16'($urandom), 16'($urandom));
        end else begin
          start_text(16'($urandom_range(SCREEN_WIDTH - 1)),
                     16'($urandom_range(SCREEN_HEIGHT - 1)), 16'($urandom));
        end
      end else if (pick < 85) begin
        // Only glyphs whose metrics and every bitmap byte are loaded may be drawn.
        ready_slots.delete();
        for (int s = 0; s < GLYPH_COUNT; s++) begin
          if (ledger.glyph_set[s]) begin
            rows = (ledger.glyphs[s].height > ROW_CAP) ? ROW_CAP
                                                       : int'(ledger.glyphs[s].height);
            n = rows * ((int'(ledger.glyphs[s].width) + 7) / 8);
            ok = 1'b1;
            for (int i = 0; ok && i < n; i++) begin
              ok = ledger.byte_set[(ledger.glyphs[s].offset + i) % BITMAP_BYTES];
            end
            if (ok) ready_slots.push_back(s);
          end
        end
        repeat ($urandom_range(8, 1)) begin
          pick = $urandom_range(99);
          if (pick < 75 && ready_slots.size() > 0) begin
            code = FIRST_CODE + 8'(ready_slots[$urandom_range(ready_slots.size() - 1)]);
          end else if (pick < 85) begin
            code = NEWLINE_CODE;
          end else begin
            code = 8'($urandom);
            while (code == NEWLINE_CODE || (code >= FIRST_CODE && code <= LAST_CODE)) begin
              code = 8'($urandom);
            end
          end
          put_char(code);
        end
      end else if ($urandom_range(1) == 0) begin
        load_glyph(7'($urandom), 6'($urandom_range(32)), 6'($urandom_range(48)),
                   13'($urandom));
      end else begin
        load_byte(13'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    ledger = new();
    rst_n              = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_ch.valid        = 1'b0;
    in_ch.func         = FUNC_LOAD_METRICS;
    in_ch.pos_x        = '0;
    in_ch.pos_y        = '0;
    in_ch.pen_in       = '0;
    in_ch.char_code    = '0;
    in_ch.glyph_slot   = '0;
    in_ch.glyph_width  = '0;
    in_ch.glyph_height = '0;
    in_ch.glyph_offset = '0;
    in_ch.bitmap_addr  = '0;
    in_ch.bitmap_byte  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Bitmap bytes at the top of the store, so glyph reads wrap to address 0.
    load_byte(13'd8190, 8'h81);
    load_byte(13'd8191, 8'hFF);
    load_byte(13'd0, 8'h80);
    load_byte(13'd1, 8'h01);
    load_byte(13'd2, 8'hAA);
    load_byte(13'd3, 8'h55);
    // Metrics loads past the last slot are dropped.
    load_glyph(7'd95, 6'd32, 6'd48, 13'd8191);
    load_glyph(7'd127, 6'd17, 6'd33, 13'd4096);
    // Full-width space, a six-row tilde, a zero-width and a zero-height glyph.
    load_glyph(7'd0, 6'd32, 6'd1, 13'd8190);
    load_glyph(7'd94, 6'd8, 6'd6, 13'd8190);
    load_glyph(7'd33, 6'd0, 6'd5, 13'd0);
    load_glyph(7'd34, 6'd5, 6'd0, 13'd0);

    // Drawing at the origin, newline and codes outside the font.
    start_text(16'd0, 16'd0, 16'hFFFF);
    put_char(FIRST_CODE);
    put_char(LAST_CODE);
    put_char(8'h41);
    put_char(8'h42);
    put_char(NEWLINE_CODE);
    put_char(8'h00);
    put_char(8'hFF);
    put_char(8'h7F);
    // Clipping at the right and bottom screen edges.
    start_text(16'd236, 16'd236, 16'h1234);
    put_char(LAST_CODE);
    // Cursor far off screen, then wrapping back to the left edge.
    start_text(16'hFFFA, 16'h0000, 16'h8001);
    put_char(FIRST_CODE);
    put_char(LAST_CODE);
    settle();

    // Extreme register settings first, then random ones.
    write_reg(CFG_IDX_LINE_SPACING, 8'd0);
    write_reg(CFG_IDX_MISSING_ADV, 8'd255);
    run_random(70, 0);
    settle();

    // A stretch with no idling on either side.
    write_reg(CFG_IDX_LINE_SPACING, 8'd255);
    write_reg(CFG_IDX_MISSING_ADV, 8'd0);
    calm = 1'b1;
    run_random(115, 0);
    settle();
    calm = 1'b0;

    write_reg(CFG_IDX_LINE_SPACING, 8'($urandom));
    write_reg(CFG_IDX_MISSING_ADV, 8'($urandom));
    run_random(160, 40);
    settle();

    if (ledger.errors == 0 && ledger.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/bftb_pkg.sv
hw/rtl/bftb_if.sv
hw/rtl/bftb_ram.sv
hw/rtl/bftb_datapath.sv
hw/rtl/bftb_ctrl.sv
hw/rtl/bitmap_font_text_blitter.sv
verif/bitmap_font_text_blitter_test.sv
